[rtl/ir_pulse_distance_decoder_defines.svh]
// Assertion macros used by the infrared decoder core.
`ifndef IR_PULSE_DISTANCE_DECODER_DEFINES_SVH
`define IR_PULSE_DISTANCE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/irpd_pkg.sv]
// Types, constants and helpers for the infrared pulse-distance decoder.
`default_nettype none
package irpd_pkg;

  // Fixed field widths
  localparam int WORD_W     = 16;
  localparam int TIMEOUT_W  = 17;
  localparam int IDX_W      = 5;
  localparam int DUR_MAX_W  = 24;

  // Parameter defaults
  localparam int HALF_FRAME_BITS_DEF = 16;
  localparam int DURATION_BITS_DEF   = 17;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 17'd100000;
  localparam logic [WORD_W-1:0]    CODE_NOKEY  = 16'hff00;

  // Timing windows in microseconds, exclusive at both ends
  localparam logic [DUR_MAX_W-1:0] LEAD_LOW_MIN  = 24'd8000;
  localparam logic [DUR_MAX_W-1:0] LEAD_LOW_MAX  = 24'd10000;
  localparam logic [DUR_MAX_W-1:0] NEW_HIGH_MIN  = 24'd4000;
  localparam logic [DUR_MAX_W-1:0] NEW_HIGH_MAX  = 24'd5000;
  localparam logic [DUR_MAX_W-1:0] REP_HIGH_MIN  = 24'd2000;
  localparam logic [DUR_MAX_W-1:0] REP_HIGH_MAX  = 24'd2500;
  localparam logic [DUR_MAX_W-1:0] REP_LOW_MIN   = 24'd500;
  localparam logic [DUR_MAX_W-1:0] REP_LOW_MAX   = 24'd700;
  localparam logic [DUR_MAX_W-1:0] BIT_LOW_MIN   = 24'd400;
  localparam logic [DUR_MAX_W-1:0] BIT_LOW_MAX   = 24'd700;
  localparam logic [DUR_MAX_W-1:0] BIT1_HIGH_MIN = 24'd1500;
  localparam logic [DUR_MAX_W-1:0] BIT1_HIGH_MAX = 24'd1800;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD_LOW,
    PH_LEAD_HIGH,
    PH_REP_LOW,
    PH_BIT_LOW,
    PH_BIT_HIGH
  } phase_t;

  typedef enum logic [1:0] {
    ST_NEW,
    ST_REPEAT,
    ST_NOKEY,
    ST_BAD
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   code;
    logic [WORD_W-1:0]   address;
  } result_t;

  function automatic logic in_window(logic [DUR_MAX_W-1:0] d,
                                     logic [DUR_MAX_W-1:0] lo,
                                     logic [DUR_MAX_W-1:0] hi);
    return (d > lo) && (d < hi);
  endfunction

endpackage
`default_nettype wire

[rtl/ir_pulse_distance_decoder.sv]
// Top level of the NEC-style infrared remote frame decoder.
`default_nettype none
// Decodes pulse-distance remote frames from a stream of finished pin intervals
// (level plus length in microseconds). Each interval word passes an input
// register, one decode pass of the frame state machine, and a result register:
// one word is accepted every cycle while the result side keeps up, and a
// result appears on out_valid when the result register takes it. A word
// waits in the input register while an earlier result is still held.
// Intervals that only advance the frame give no result. Results: new frame,
// repeat, no key (idle high past the cfg timeout) or malformed. The timeout
// register is written through cfg_we/cfg_wdata and resets to 100000 us; write
// it only while the decoder is idle. No clearing pass is needed after reset.
module ir_pulse_distance_decoder import irpd_pkg::*; #(
  parameter int HALF_FRAME_BITS = HALF_FRAME_BITS_DEF,
  parameter int DURATION_BITS   = DURATION_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [TIMEOUT_W-1:0]     cfg_wdata,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic                     in_level,
  input  wire logic [DURATION_BITS-1:0] in_duration_us,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic [1:0]               out_status,
  output      logic [WORD_W-1:0]        out_code,
  output      logic [WORD_W-1:0]        out_address
);

  logic                     take;
  logic                     item_valid;
  logic                     item_level;
  logic [DURATION_BITS-1:0] item_duration;
  logic                     out_free;
  logic                     res_load;
  result_t                  res;
  result_t                  out_res;

  irpd_in_stage #(
    .DURATION_BITS(DURATION_BITS)
  ) u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_level      (in_level),
    .in_duration_us(in_duration_us),
    .take          (take),
    .item_valid    (item_valid),
    .item_level    (item_level),
    .item_duration (item_duration)
  );

  irpd_core #(
    .HALF_FRAME_BITS(HALF_FRAME_BITS),
    .DURATION_BITS  (DURATION_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_level   (item_level),
    .item_duration(item_duration),
    .out_free     (out_free),
    .take         (take),
    .res_load     (res_load),
    .res          (res)
  );

  irpd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_load (res_load),
    .res      (res),
    .out_free (out_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_status  = out_res.status;
  assign out_code    = out_res.code;
  assign out_address = out_res.address;

endmodule
`default_nettype wire

[rtl/irpd_in_stage.sv]
// Input register: holds one interval word until the decoder takes it.
`default_nettype none
module irpd_in_stage import irpd_pkg::*; #(
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic                     in_level,
  input  wire logic [DURATION_BITS-1:0] in_duration_us,
  input  wire logic                     take,
  output      logic                     item_valid,
  output      logic                     item_level,
  output      logic [DURATION_BITS-1:0] item_duration
);

  logic                     valid_r, valid_nxt;
  logic                     level_r;
  logic [DURATION_BITS-1:0] dur_r;
  logic                     load;

  // Free when empty or when the held word leaves this cycle
  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      level_r <= in_level;
      dur_r   <= in_duration_us;
    end
  end

  assign item_valid    = valid_r;
  assign item_level    = level_r;
  assign item_duration = dur_r;

endmodule
`default_nettype wire

[rtl/irpd_core.sv]
// Frame decoder: protocol state machine, shift words and timeout register.
`default_nettype none
`include "ir_pulse_distance_decoder_defines.svh"
module irpd_core import irpd_pkg::*; #(
  parameter int HALF_FRAME_BITS = HALF_FRAME_BITS_DEF,
  parameter int DURATION_BITS   = DURATION_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [TIMEOUT_W-1:0]     cfg_wdata,
  input  wire logic                     item_valid,
  input  wire logic                     item_level,
  input  wire logic [DURATION_BITS-1:0] item_duration,
  input  wire logic                     out_free,
  output      logic                     take,
  output      logic                     res_load,
  output      result_t                  res
);

  localparam logic [IDX_W-1:0] HALF_IDX = IDX_W'(HALF_FRAME_BITS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(2 * HALF_FRAME_BITS - 1);

  phase_t                  phase_r, phase_nxt;
  logic [IDX_W-1:0]        bit_idx_r, bit_idx_nxt;
  logic                    low_ok_r, low_ok_nxt;
  logic [WORD_W-1:0]       addr_r, addr_nxt;
  logic [WORD_W-1:0]       code_r, code_nxt;
  logic [TIMEOUT_W-1:0]    timeout_r;

  logic [DUR_MAX_W-1:0]    d;
  logic                    emit;
  logic                    out_of_turn;
  logic                    bit_one;
  logic [3:0]              code_pos;
  status_t                 status;
  logic [WORD_W-1:0]       code_out;

  assign d        = DUR_MAX_W'(item_duration);
  assign code_pos = 4'(bit_idx_r - HALF_IDX);
  assign bit_one  = low_ok_r && in_window(d, BIT1_HIGH_MIN, BIT1_HIGH_MAX);

  // Decoder takes a word whenever the result slot can receive
  assign take = item_valid && out_free;

  // Next state and result
  always_comb begin
    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    low_ok_nxt  = low_ok_r;
    addr_nxt    = addr_r;
    code_nxt    = code_r;
    emit        = 1'b0;
    out_of_turn = 1'b0;
    status      = ST_BAD;
    code_out    = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (!item_level) begin
          // low while idle is taken as the leader low
          if (in_window(d, LEAD_LOW_MIN, LEAD_LOW_MAX)) begin
            phase_nxt = PH_LEAD_HIGH;
          end else begin
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
          end
        end else if (d > DUR_MAX_W'(timeout_r)) begin
          code_nxt = CODE_NOKEY;
          emit     = 1'b1;
          status   = ST_NOKEY;
        end else begin
          phase_nxt = PH_LEAD_LOW;
        end
      end
      PH_LEAD_LOW: begin
        if (item_level) begin
          out_of_turn = 1'b1;
        end else if (in_window(d, LEAD_LOW_MIN, LEAD_LOW_MAX)) begin
          phase_nxt = PH_LEAD_HIGH;
        end else begin
          phase_nxt = PH_IDLE;
          emit      = 1'b1;
        end
      end
      PH_LEAD_HIGH: begin
        if (!item_level) begin
          out_of_turn = 1'b1;
        end else if (in_window(d, NEW_HIGH_MIN, NEW_HIGH_MAX)) begin
          addr_nxt    = '0;
          bit_idx_nxt = '0;
          phase_nxt   = PH_BIT_LOW;
        end else if (in_window(d, REP_HIGH_MIN, REP_HIGH_MAX)) begin
          phase_nxt = PH_REP_LOW;
        end else begin
          phase_nxt = PH_IDLE;
          emit      = 1'b1;
        end
      end
      PH_REP_LOW: begin
        if (item_level) begin
          out_of_turn = 1'b1;
        end else begin
          phase_nxt = PH_IDLE;
          emit      = 1'b1;
          if (in_window(d, REP_LOW_MIN, REP_LOW_MAX)) begin
            status   = ST_REPEAT;
            code_out = code_r;
          end
        end
      end
      PH_BIT_LOW: begin
        if (item_level) begin
          out_of_turn = 1'b1;
        end else begin
          low_ok_nxt = in_window(d, BIT_LOW_MIN, BIT_LOW_MAX);
          phase_nxt  = PH_BIT_HIGH;
        end
      end
      PH_BIT_HIGH: begin
        if (!item_level) begin
          out_of_turn = 1'b1;
        end else begin
          // address bits first, then code bits, LSB first
          if (bit_idx_r < HALF_IDX) begin
            if (bit_one) begin
              addr_nxt[bit_idx_r[3:0]] = 1'b1;
            end
          end else begin
            if (bit_idx_r == HALF_IDX) begin
              code_nxt = '0;
            end
            if (bit_one) begin
              code_nxt[code_pos] = 1'b1;
            end
          end
          low_ok_nxt = 1'b0;
          if (bit_idx_r == LAST_IDX) begin
            bit_idx_nxt = '0;
            phase_nxt   = PH_IDLE;
            emit        = 1'b1;
            status      = ST_NEW;
            code_out    = code_nxt;
          end else begin
            bit_idx_nxt = bit_idx_r + 1'b1;
            phase_nxt   = PH_BIT_LOW;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    // level out of turn aborts the frame
    if (out_of_turn) begin
      phase_nxt  = PH_IDLE;
      low_ok_nxt = 1'b0;
      emit       = 1'b1;
      status     = ST_BAD;
      code_out   = '0;
    end
  end

  assign res_load    = take && emit;
  assign res.status  = status;
  assign res.code    = code_out;
  assign res.address = addr_nxt;

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_idx_r <= '0;
      low_ok_r  <= 1'b0;
      addr_r    <= '0;
      code_r    <= '0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      bit_idx_r <= bit_idx_nxt;
      low_ok_r  <= low_ok_nxt;
      addr_r    <= addr_nxt;
      code_r    <= code_nxt;
    end
  end

  // Idle timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  `IRPD_ASSERT_NOW(a_fail_code_zero, clk, rst_n, res_load && (res.status == ST_NOKEY || res.status == ST_BAD), res.code == '0, "no-key or malformed word carries a nonzero code")
  `IRPD_ASSERT_NEXT(a_frame_end_idle, clk, rst_n, res_load && res.status == ST_NEW, phase_r == PH_IDLE && bit_idx_r == '0, "decoder not idle after a full frame")
  `IRPD_ASSERT_NEXT(a_nokey_loads_code, clk, rst_n, res_load && res.status == ST_NOKEY, code_r == CODE_NOKEY, "no-key did not load the idle code")
  `IRPD_ASSERT_NOW(a_idx_in_frame, clk, rst_n, 1'b1, bit_idx_r <= LAST_IDX, "bit index past end of frame")
  `IRPD_ASSERT_NOW(a_load_needs_slot, clk, rst_n, res_load, out_free && item_valid, "result produced without a free output slot")

endmodule
`default_nettype wire

[rtl/irpd_out_stage.sv]
// Result register: holds one decoded word until the consumer takes it.
`default_nettype none
module irpd_out_stage import irpd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_load,
  input  wire result_t res,
  output      logic    out_free,
  output      logic    out_valid,
  input  wire logic    out_ready,
  output      result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Slot frees when empty or when the held word is taken this cycle
  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire
